// File: hdl/bfpu_pkg.sv
package bfpu_pkg;

    localparam int LEN_W     = 15;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 15;
    localparam int TAKE_W    = 4;

    localparam int STORE_BYTES_DEF    = 2048;
    localparam int MAX_FIELD_BITS_DEF = 32;

    localparam logic [LEN_W-1:0] MAX_BITS_RST = 15'd16384;

    localparam logic [1:0] OP_WRITE       = 2'd0;
    localparam logic [1:0] OP_READ        = 2'd1;
    localparam logic [1:0] OP_BEGIN_WRITE = 2'd2;
    localparam logic [1:0] OP_BEGIN_READ  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FATAL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADCOUNT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BITS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_OVF = 1'b1;

    typedef struct packed {
        logic [7:0]         byte_in;
        logic [2:0]         offset;
        logic [COUNT_W-1:0] rem;
        logic [7:0]         data_lo;
    } chunk_req_t;

    typedef struct packed {
        logic [TAKE_W-1:0] take;
        logic [7:0]        byte_out;
        logic [7:0]        bits;
    } chunk_rsp_t;

endpackage

// File: hdl/bfpu_in_if.sv
interface bfpu_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           op;
    logic [bfpu_pkg::VALUE_W-1:0]         value;
    logic signed [bfpu_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output op, output value, output count, input ready);
    modport sink (input valid, input op, input value, input count, output ready);
endinterface

// File: hdl/bfpu_out_if.sv
interface bfpu_out_if;
    logic                          valid;
    logic                          ready;
    logic [bfpu_pkg::VALUE_W-1:0]  read_value;
    logic [bfpu_pkg::STATUS_W-1:0] status;
    logic [bfpu_pkg::LEN_W-1:0]    length_bits;
    logic                          overflowed;

    modport source (output valid, output read_value, output status, output length_bits,
                    output overflowed, input ready);
    modport sink (input valid, input read_value, input status, input length_bits,
                  input overflowed, output ready);
endinterface

// File: hdl/bfpu_store.sv
module bfpu_store #(
    parameter int DEPTH  = bfpu_pkg::STORE_BYTES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: hdl/bfpu_chunk.sv
module bfpu_chunk (
    input  bfpu_pkg::chunk_req_t req,
    output bfpu_pkg::chunk_rsp_t rsp
);
    import bfpu_pkg::*;

    logic [TAKE_W-1:0] avail;
    logic [TAKE_W-1:0] take;
    logic [7:0]        mask;
    logic [7:0]        wmask;

    always_comb
    begin
        avail = TAKE_W'(4'd8 - {1'b0, req.offset});
        if (req.rem < COUNT_W'(avail))
        begin
            take = TAKE_W'(req.rem);
        end
        else
        begin
            take = avail;
        end
        mask  = 8'((9'd1 << take) - 9'd1);
        wmask = mask << req.offset;
        rsp.take     = take;
        rsp.byte_out = (req.byte_in & ~wmask) | ((req.data_lo << req.offset) & wmask);
        rsp.bits     = (req.byte_in >> req.offset) & mask;
    end

endmodule

// File: hdl/bit_field_packer_unpacker.sv
// Begin items and items refused at decode give their result in the cycle after acceptance.
// A field item visits each byte it touches in a read state, then a merge or extract state,
// and a 32-bit field touches 1 to 5 bytes; the result follows the step on its last byte.
// One item at a time; ready returns after the result is taken.
// Reset is asynchronous: lengths, cursor and overflow mark clear, max_bits = 16384,
// allow_overflow = 0; the bit store is not cleared.
module bit_field_packer_unpacker #(
    parameter int STORE_BYTES    = bfpu_pkg::STORE_BYTES_DEF,
    parameter int MAX_FIELD_BITS = bfpu_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bfpu_in_if.sink                        in_ch,
    bfpu_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [bfpu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfpu_pkg::CFG_W-1:0]     cfg_wdata
);
    import bfpu_pkg::*;

    localparam int ADDR_W     = $clog2(STORE_BYTES);
    localparam int STORE_BITS = STORE_BYTES * 8;
    localparam int SB_W       = $clog2(STORE_BITS + 1);
    localparam int CAP_W      = (SB_W > LEN_W + 1) ? SB_W : LEN_W + 1;
    localparam int FW         = MAX_FIELD_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_MOD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [LEN_W-1:0]    max_bits_reg;
    logic                allow_ovf_reg;
    logic [LEN_W-1:0]    wl_reg, wl_next;
    logic [LEN_W-1:0]    rc_reg, rc_next;
    logic                ovf_reg, ovf_next;
    logic                is_write_reg, is_write_next;
    logic [LEN_W-1:0]    pos_reg, pos_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [COUNT_W-1:0]  boff_reg, boff_next;
    logic [FW-1:0]       data_reg, data_next;
    logic [FW-1:0]       acc_reg, acc_next;
    logic [VALUE_W-1:0]  rv_reg, rv_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [COUNT_W-1:0]  cnt_raw;
    logic [COUNT_W-1:0]  mag;
    logic [COUNT_W-1:0]  n;
    logic                n_ok;
    logic [CAP_W-1:0]    cap;
    logic [CAP_W-1:0]    wr_end;
    logic [LEN_W:0]      rd_end;
    logic                accept;
    logic [7:0]          rdata;
    chunk_req_t          creq;
    chunk_rsp_t          crsp;

    bfpu_store #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    ((state_reg == S_MOD) && is_write_reg),
        .re    (state_reg == S_RD),
        .addr  (ADDR_W'(pos_reg >> 3)),
        .wdata (crsp.byte_out),
        .rdata (rdata)
    );

    assign creq.byte_in = rdata;
    assign creq.offset  = pos_reg[2:0];
    assign creq.rem     = rem_reg;
    assign creq.data_lo = data_reg[7:0];

    bfpu_chunk u_chunk (
        .req (creq),
        .rsp (crsp)
    );

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign accept             = in_ch.valid && in_ch.ready;
    assign out_ch.valid       = (state_reg == S_DONE);
    assign out_ch.read_value  = rv_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.length_bits = wl_reg;
    assign out_ch.overflowed  = ovf_reg;

    always_comb
    begin
        cnt_raw = in_ch.count;
        mag     = COUNT_W'(7'd0 - cnt_raw);
        if (cnt_raw[COUNT_W-1])
        begin
            n    = mag;
            n_ok = ({1'b0, mag} <= 8'(MAX_FIELD_BITS - 1));
        end
        else
        begin
            n    = cnt_raw;
            n_ok = (cnt_raw != '0) && ({1'b0, cnt_raw} <= 8'(MAX_FIELD_BITS));
        end
        if (CAP_W'(max_bits_reg) < CAP_W'(STORE_BITS))
        begin
            cap = CAP_W'(max_bits_reg);
        end
        else
        begin
            cap = CAP_W'(STORE_BITS);
        end
        wr_end = CAP_W'(wl_reg) + CAP_W'(n);
        rd_end = (LEN_W + 1)'(rc_reg) + (LEN_W + 1)'(n);
    end

    always_comb
    begin
        state_next    = state_reg;
        wl_next       = wl_reg;
        rc_next       = rc_reg;
        ovf_next      = ovf_reg;
        is_write_next = is_write_reg;
        pos_next      = pos_reg;
        rem_next      = rem_reg;
        boff_next     = boff_reg;
        data_next     = data_reg;
        acc_next      = acc_reg;
        rv_next       = rv_reg;
        status_next   = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rv_next       = '0;
                    status_next   = ST_OK;
                    state_next    = S_DONE;
                    is_write_next = (in_ch.op == OP_WRITE);
                    rem_next      = n;
                    boff_next     = '0;
                    data_next     = FW'(in_ch.value);
                    acc_next      = '0;
                    if (in_ch.op == OP_BEGIN_WRITE)
                    begin
                        wl_next  = '0;
                        ovf_next = 1'b0;
                    end
                    else if (in_ch.op == OP_BEGIN_READ)
                    begin
                        rc_next = '0;
                    end
                    else if (!n_ok)
                    begin
                        status_next = ST_BADCOUNT;
                    end
                    else if (in_ch.op == OP_WRITE)
                    begin
                        if (wr_end > cap)
                        begin
                            if (allow_ovf_reg)
                            begin
                                wl_next     = '0;
                                ovf_next    = 1'b1;
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                status_next = ST_FATAL;
                            end
                        end
                        else
                        begin
                            pos_next   = wl_reg;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        if (rd_end > (LEN_W + 1)'(wl_reg))
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            pos_next   = rc_reg;
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                pos_next  = pos_reg + LEN_W'(crsp.take);
                rem_next  = rem_reg - COUNT_W'(crsp.take);
                boff_next = boff_reg + COUNT_W'(crsp.take);
                data_next = data_reg >> crsp.take;
                acc_next  = acc_reg | (FW'(crsp.bits) << boff_reg);
                if (rem_next == '0)
                begin
                    state_next = S_DONE;
                    if (is_write_reg)
                    begin
                        wl_next = pos_next;
                    end
                    else
                    begin
                        rc_next = pos_next;
                        rv_next = VALUE_W'(acc_next);
                    end
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_bits_reg  <= MAX_BITS_RST;
            allow_ovf_reg <= 1'b0;
            wl_reg        <= '0;
            rc_reg        <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wl_reg    <= wl_next;
            rc_reg    <= rc_next;
            ovf_reg   <= ovf_next;
            if (cfg_we && (cfg_index == CFG_MAX_BITS))
            begin
                max_bits_reg <= cfg_wdata[LEN_W-1:0];
            end
            if (cfg_we && (cfg_index == CFG_ALLOW_OVF))
            begin
                allow_ovf_reg <= cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        is_write_reg <= is_write_next;
        pos_reg      <= pos_next;
        rem_reg      <= rem_next;
        boff_reg     <= boff_next;
        data_reg     <= data_next;
        acc_reg      <= acc_next;
        rv_reg       <= rv_next;
        status_reg   <= status_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ch.ready)
        else $error("Block stayed ready after accepting an item.");

    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready) |=> in_ch.ready)
        else $error("Block did not return to ready after its result was taken.");

    a_chunk_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> (rem_reg != '0))
        else $error("Byte step entered with no bits left.");

    a_refused_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (status_reg != ST_OK)) |-> (rv_reg == '0))
        else $error("Refused item returned nonzero read data.");

    a_length_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        CAP_W'(wl_reg) <= CAP_W'(STORE_BITS))
        else $error("Write length passed the store size.");
`endif

endmodule
